[sv/dmsl_pkg.sv]
package dmsl_pkg;

  localparam int unsigned COUNTER_BITS = 16;
  localparam int unsigned CFG_W        = 16;
  localparam int unsigned STEP_W       = 7;
  localparam int unsigned SPEED_W      = 8;
  localparam int unsigned CMP_W        = (COUNTER_BITS > CFG_W) ? COUNTER_BITS : CFG_W;

  localparam logic [SPEED_W-1:0] NEUTRAL   = SPEED_W'(90);
  localparam logic [SPEED_W-1:0] SPEED_MAX = SPEED_W'(180);

  localparam logic [CFG_W-1:0]  INTERVAL_RESET = CFG_W'(20);
  localparam logic [CFG_W-1:0]  TIMEOUT_RESET  = CFG_W'(500);
  localparam logic [STEP_W-1:0] STEP_RESET     = STEP_W'(10);

  localparam logic [1:0] CFG_IDX_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_IDX_TIMEOUT  = 2'd1;
  localparam logic [1:0] CFG_IDX_STEP     = 2'd2;

  localparam logic [0:0] OP_TICK    = 1'b0;
  localparam logic [0:0] OP_COMMAND = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0]  control_interval;
    logic [CFG_W-1:0]  stop_timeout;
    logic [STEP_W-1:0] ramp_step;
  } cfg_t;

  function automatic logic [SPEED_W-1:0] approach(
    input logic [SPEED_W-1:0] cur,
    input logic [SPEED_W-1:0] want,
    input logic [STEP_W-1:0]  step
  );
    logic [SPEED_W-1:0] gap;
    logic [SPEED_W-1:0] step_x;
    logic [SPEED_W-1:0] res;
    step_x = SPEED_W'(step);
    gap    = (want > cur) ? (want - cur) : (cur - want);
    if (gap < step_x) begin
      res = want;
    end else if (want > cur) begin
      res = cur + step_x;
    end else begin
      res = cur - step_x;
    end
    return res;
  endfunction

  function automatic logic [SPEED_W-1:0] clamp_speed(input logic [SPEED_W-1:0] v);
    return (v > SPEED_MAX) ? SPEED_MAX : v;
  endfunction

endpackage

[sv/dmsl_cfg.sv]
module dmsl_cfg import dmsl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDX_INTERVAL: cfg_d.control_interval = cfg_wdata_i;
        CFG_IDX_TIMEOUT:  cfg_d.stop_timeout     = cfg_wdata_i;
        CFG_IDX_STEP:     cfg_d.ramp_step        = cfg_wdata_i[STEP_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.control_interval <= INTERVAL_RESET;
      cfg_q.stop_timeout     <= TIMEOUT_RESET;
      cfg_q.ramp_step        <= STEP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/dual_motor_slew_limiter.sv]
// Two-channel servo slew limiter with command watchdog. Each accepted beat is a
// 1 ms tick (opcode 0) or a speed command (opcode 1) and yields exactly one result
// beat with both drive values and the brake release flag. All work is done in the
// accept cycle into the output register, so one beat is taken per clock; the output
// register is refilled in the same cycle it is drained, and in_stall_o rises only
// while a held result is stalled. Configuration takes effect from the next beat.
module dual_motor_slew_limiter import dmsl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [0:0]         opcode_i,
  input  logic [SPEED_W-1:0] target_left_i,
  input  logic [SPEED_W-1:0] target_right_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [SPEED_W-1:0] left_drive_o,
  output logic [SPEED_W-1:0] right_drive_o,
  output logic               brake_release_o
);

  localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

  cfg_t cfg;

  dmsl_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .cfg_o (cfg)
  );

  logic [SPEED_W-1:0]      cur_l_q, cur_l_d, cur_r_q, cur_r_d;
  logic [SPEED_W-1:0]      want_l_q, want_l_d, want_r_q, want_r_d;
  logic [COUNTER_BITS-1:0] since_ramp_q, since_ramp_d, since_cmd_q, since_cmd_d;
  logic                    out_valid_q;
  logic [SPEED_W-1:0]      left_q, right_q;
  logic                    brake_q;

  logic                    accept;
  logic [COUNTER_BITS-1:0] sr_inc, sc_inc;
  logic                    ramp_due, timeout_due;
  logic [SPEED_W-1:0]      tgt_l, tgt_r, mid_l, mid_r;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign sr_inc      = (since_ramp_q == CNT_MAX) ? CNT_MAX : since_ramp_q + 1'b1;
  assign sc_inc      = (since_cmd_q == CNT_MAX) ? CNT_MAX : since_cmd_q + 1'b1;
  assign ramp_due    = CMP_W'(sr_inc) >= CMP_W'(cfg.control_interval);
  assign timeout_due = CMP_W'(sc_inc) >= CMP_W'(cfg.stop_timeout);
  assign tgt_l       = clamp_speed(target_left_i);
  assign tgt_r       = clamp_speed(target_right_i);
  assign mid_l       = ramp_due ? approach(cur_l_q, want_l_q, cfg.ramp_step) : cur_l_q;
  assign mid_r       = ramp_due ? approach(cur_r_q, want_r_q, cfg.ramp_step) : cur_r_q;

  always_comb begin
    cur_l_d      = cur_l_q;
    cur_r_d      = cur_r_q;
    want_l_d     = want_l_q;
    want_r_d     = want_r_q;
    since_ramp_d = since_ramp_q;
    since_cmd_d  = since_cmd_q;
    if (accept) begin
      if (opcode_i == OP_COMMAND) begin
        want_l_d    = tgt_l;
        want_r_d    = tgt_r;
        since_cmd_d = '0;
        cur_l_d     = approach(cur_l_q, tgt_l, cfg.ramp_step);
        cur_r_d     = approach(cur_r_q, tgt_r, cfg.ramp_step);
      end else begin
        since_ramp_d = ramp_due ? '0 : sr_inc;
        if (timeout_due) begin
          want_l_d    = NEUTRAL;
          want_r_d    = NEUTRAL;
          since_cmd_d = '0;
          cur_l_d     = approach(mid_l, NEUTRAL, cfg.ramp_step);
          cur_r_d     = approach(mid_r, NEUTRAL, cfg.ramp_step);
        end else begin
          since_cmd_d = sc_inc;
          cur_l_d     = mid_l;
          cur_r_d     = mid_r;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_l_q      <= NEUTRAL;
      cur_r_q      <= NEUTRAL;
      want_l_q     <= NEUTRAL;
      want_r_q     <= NEUTRAL;
      since_ramp_q <= '0;
      since_cmd_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      cur_l_q      <= cur_l_d;
      cur_r_q      <= cur_r_d;
      want_l_q     <= want_l_d;
      want_r_q     <= want_r_d;
      since_ramp_q <= since_ramp_d;
      since_cmd_q  <= since_cmd_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      left_q  <= cur_l_d;
      right_q <= cur_r_d;
      brake_q <= (cur_l_d != NEUTRAL) | (cur_r_d != NEUTRAL);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign left_drive_o    = left_q;
  assign right_drive_o   = right_q;
  assign brake_release_o = brake_q;

endmodule

[verif/dmsl_checker.sv]
module dmsl_checker import dmsl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [0:0]         opcode_i,
  input  logic [SPEED_W-1:0] target_left_i,
  input  logic [SPEED_W-1:0] target_right_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [SPEED_W-1:0] left_drive_i,
  input  logic [SPEED_W-1:0] right_drive_i,
  input  logic               brake_release_i,
  output int                 errors_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [SPEED_W-1:0] left_drive;
    logic [SPEED_W-1:0] right_drive;
    logic               brake;
  } drive_beat_t;

  drive_beat_t drives_q[$];

  logic [CFG_W-1:0]        interval_r;
  logic [CFG_W-1:0]        timeout_r;
  logic [STEP_W-1:0]       step_r;
  logic [SPEED_W-1:0]      cur_l, cur_r, want_l, want_r;
  logic [COUNTER_BITS-1:0] ramp_cnt, cmd_cnt;

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  function automatic logic [SPEED_W-1:0] slew(input logic [SPEED_W-1:0] cur,
                                              input logic [SPEED_W-1:0] want);
    int unsigned gap;
    gap = (want > cur) ? int'(want) - int'(cur) : int'(cur) - int'(want);
    if (gap < step_r) return want;
    return (want > cur) ? SPEED_W'(cur + step_r) : SPEED_W'(cur - step_r);
  endfunction

  task automatic ramp_once();
    cur_l = slew(cur_l, want_l);
    cur_r = slew(cur_r, want_r);
  endtask

  task automatic note_fault(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    drive_beat_t want_beat;
    if (!rst_ni) begin
      interval_r = INTERVAL_RESET;
      timeout_r  = TIMEOUT_RESET;
      step_r     = STEP_RESET;
      cur_l      = NEUTRAL;
      cur_r      = NEUTRAL;
      want_l     = NEUTRAL;
      want_r     = NEUTRAL;
      ramp_cnt   = '0;
      cmd_cnt    = '0;
      drives_q.delete();
      pending_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IDX_INTERVAL: interval_r = cfg_wdata_i;
          CFG_IDX_TIMEOUT:  timeout_r  = cfg_wdata_i;
          CFG_IDX_STEP:     step_r     = cfg_wdata_i[STEP_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        if (drives_q.size() == 0) begin
          note_fault($sformatf("unexpected result beat left %0d right %0d brake %0b",
                               left_drive_i, right_drive_i, brake_release_i));
        end else begin
          want_beat = drives_q.pop_front();
          if (left_drive_i !== want_beat.left_drive)
            note_fault($sformatf("left_drive got %0d expected %0d",
                                 left_drive_i, want_beat.left_drive));
          if (right_drive_i !== want_beat.right_drive)
            note_fault($sformatf("right_drive got %0d expected %0d",
                                 right_drive_i, want_beat.right_drive));
          if (brake_release_i !== want_beat.brake)
            note_fault($sformatf("brake_release got %0b expected %0b",
                                 brake_release_i, want_beat.brake));
        end
      end

      if (in_valid_i && !in_stall_i) begin
        if (opcode_i == OP_COMMAND) begin
          want_l  = (target_left_i > SPEED_MAX) ? SPEED_MAX : target_left_i;
          want_r  = (target_right_i > SPEED_MAX) ? SPEED_MAX : target_right_i;
          cmd_cnt = '0;
          ramp_once();
        end else begin
          if (ramp_cnt != '1) ramp_cnt = ramp_cnt + 1'b1;
          if (cmd_cnt != '1) cmd_cnt = cmd_cnt + 1'b1;
          if (ramp_cnt >= interval_r) begin
            ramp_once();
            ramp_cnt = '0;
          end
          if (cmd_cnt >= timeout_r) begin
            want_l  = NEUTRAL;
            want_r  = NEUTRAL;
            cmd_cnt = '0;
            ramp_once();
          end
        end
        drives_q.push_back('{left_drive:  cur_l,
                             right_drive: cur_r,
                             brake:       !(cur_l == NEUTRAL && cur_r == NEUTRAL)});
      end
      pending_o = drives_q.size();
    end
  end

endmodule

[verif/dual_motor_slew_limiter_tb.sv]
module dual_motor_slew_limiter_tb;
  import dmsl_pkg::*;

  localparam int LIMIT = 1_000_000;
  localparam logic [1:0] CFG_IDX_SPARE = 2'd3;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic [1:0]         cfg_idx_i      = CFG_IDX_INTERVAL;
  logic [CFG_W-1:0]   cfg_wdata_i    = '0;
  logic               in_valid_i     = 1'b0;
  logic [0:0]         opcode_i       = OP_TICK;
  logic [SPEED_W-1:0] target_left_i  = '0;
  logic [SPEED_W-1:0] target_right_i = '0;
  logic               out_stall_i    = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic [SPEED_W-1:0] left_drive_o;
  logic [SPEED_W-1:0] right_drive_o;
  logic               brake_release_o;

  int send_gap_pct = 0;
  int stall_pct    = 0;
  int fault_count;
  int pending_beats;
  int cycle_count  = 0;

  int unsigned intervals[6] = '{3, 1, 7, 0, 2, 5};
  int unsigned timeouts[6]  = '{25, 8, 60, 1, 15, 40};
  int unsigned steps[6]     = '{10, 45, 3, 127, 1, 90};
  int          cmd_pcts[6]  = '{10, 20, 5, 30, 15, 8};
  int          gap_pcts[3]  = '{17, 82, 0};
  int          stl_pcts[3]  = '{82, 17, 0};

  always #1 clk_i = ~clk_i;

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  dual_motor_slew_limiter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .target_left_i   (target_left_i),
    .target_right_i  (target_right_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .left_drive_o    (left_drive_o),
    .right_drive_o   (right_drive_o),
    .brake_release_o (brake_release_o)
  );

  dmsl_checker drive_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .opcode_i        (opcode_i),
    .target_left_i   (target_left_i),
    .target_right_i  (target_right_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .left_drive_i    (left_drive_o),
    .right_drive_i   (right_drive_o),
    .brake_release_i (brake_release_o),
    .errors_o        (fault_count),
    .pending_o       (pending_beats)
  );

  task automatic send_beat(input logic [0:0] op, input logic [SPEED_W-1:0] tl,
                           input logic [SPEED_W-1:0] tr);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    target_left_i  <= tl;
    target_right_i <= tr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_beats != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic configure(input int unsigned interval, input int unsigned timeout,
                           input int unsigned step);
    logic [CFG_W-1:0] step_word;
    step_word = CFG_W'($urandom);
    step_word[STEP_W-1:0] = STEP_W'(step);
    drain();
    write_reg(CFG_IDX_INTERVAL, CFG_W'(interval));
    write_reg(CFG_IDX_TIMEOUT, CFG_W'(timeout));
    write_reg(CFG_IDX_STEP, step_word);
  endtask

  function automatic logic [SPEED_W-1:0] pick_speed();
    case ($urandom_range(9))
      0:       return SPEED_W'($urandom_range(255));
      1:       return NEUTRAL;
      2:       return $urandom_range(1) ? SPEED_MAX : '0;
      default: return SPEED_W'($urandom_range(180));
    endcase
  endfunction

  task automatic random_beats(input int count, input int cmd_pct);
    logic [0:0] op;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(59) == 0) drain();
      op = ($urandom_range(99) < cmd_pct) ? OP_COMMAND : OP_TICK;
      send_beat(op, pick_speed(), pick_speed());
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings, clamping of targets above full speed
    send_beat(OP_COMMAND, SPEED_MAX, 8'd0);
    send_beat(OP_COMMAND, 8'd255, 8'd181);
    send_beat(OP_TICK, 8'hFF, 8'hFF);
    send_beat(OP_COMMAND, NEUTRAL, NEUTRAL);
    send_beat(OP_COMMAND, 8'd0, SPEED_MAX);

    // zero interval and timeout act on every tick; step beyond 90
    configure(0, 0, 127);
    send_beat(OP_TICK, 8'd0, 8'd0);
    send_beat(OP_COMMAND, SPEED_MAX, 8'd0);
    send_beat(OP_TICK, 8'd0, 8'd0);

    // zero step freezes the drives
    configure(0, 0, 0);
    send_beat(OP_COMMAND, 8'd0, 8'd0);
    send_beat(OP_TICK, 8'hAA, 8'h55);

    configure(1, 2, 90);
    send_beat(OP_COMMAND, 8'd0, SPEED_MAX);
    send_beat(OP_TICK, 8'd0, 8'd0);
    send_beat(OP_TICK, 8'd0, 8'd0);
    send_beat(OP_TICK, 8'd0, 8'd0);

    // write to an unused index must be ignored
    drain();
    write_reg(CFG_IDX_SPARE, '1);
    send_beat(OP_COMMAND, 8'd17, 8'd163);
    send_beat(OP_TICK, 8'd0, 8'd0);

    for (int ph = 0; ph < 3; ph++) begin
      for (int k = 0; k < 2; k++) begin
        configure(intervals[2*ph+k], timeouts[2*ph+k], steps[2*ph+k]);
        send_gap_pct = gap_pcts[ph];
        stall_pct    = stl_pcts[ph];
        random_beats(130, cmd_pcts[2*ph+k]);
      end
    end

    // interval and timeout elapsing on the same tick
    configure(1, 12, 1);
    send_beat(OP_COMMAND, 8'd0, SPEED_MAX);
    repeat (36) send_beat(OP_TICK, pick_speed(), pick_speed());

    drain();
    repeat (10) @(negedge clk_i);
    if (fault_count == 0 && pending_beats == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/dmsl_pkg.sv
sv/dmsl_cfg.sv
sv/dual_motor_slew_limiter.sv
verif/dmsl_checker.sv
verif/dual_motor_slew_limiter_tb.sv
